>>> design/rfsc_pkg.sv
// shared types, constants and helper functions of the range filter stream compactor
package rfsc_pkg;

  // number of values compared and packed side by side
  localparam int LANES       = 4;
  // value lanes carried by the stream fields
  localparam int FIELD_LANES = 4;
  // lanes that reach the stream fields
  localparam int SHOWN_LANES = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;

  localparam int VAL_W  = 64;
  localparam int KEEP_W = 32;
  localparam int IN_W   = FIELD_LANES * VAL_W;
  localparam int OUT_W  = FIELD_LANES * VAL_W + KEEP_W;

  // packed entry count, always below LANES between beats
  localparam int CNT_W = $clog2(LANES + 1);
  // entry count after appending one beat, up to 2*LANES-1
  localparam int SUM_W = $clog2(2 * LANES);

  // configuration port
  localparam int CFG_W  = 64;
  localparam int ADDR_W = 4;

  typedef enum logic {
    REG_LOWER = 1'b0,
    REG_UPPER = 1'b1
  } reg_e;

  typedef logic [VAL_W-1:0] val_t;

  typedef struct packed {
    val_t lower;
    val_t upper;
  } bounds_t;

  typedef struct packed {
    logic                          last;
    logic [KEEP_W-1:0]             keep;
    logic [FIELD_LANES-1:0][VAL_W-1:0] vals;
  } beat_t;

  typedef struct packed {
    logic  valid;
    beat_t beat;
  } push_t;

  // byte mask covering eight bytes per value, clipped to the keep width
  function automatic logic [KEEP_W-1:0] keep_mask(input logic [CNT_W-1:0] n);
    logic [KEEP_W-1:0] m;
    m = '0;
    for (int b = 0; b < KEEP_W; b++) begin
      m[b] = ((b / 8) < int'(n));
    end
    return m;
  endfunction

endpackage

>>> design/range_filter_stream_compactor.sv
// top level of the range filter stream compactor: config registers, lanes, merge, output queue
//
// Each input beat carries four 64-bit values; a value is kept when it lies
// between the lower and the upper bound, both inclusive. Kept values are packed
// in order into full output beats (keep all ones). One beat is held back so
// the final beat carries tlast. A stream end sends the remainder as a partial
// beat whose keep covers eight bytes per value, or a zero beat with keep 0x01
// when nothing was kept. Beats are taken one per cycle while the stream runs
// and the output queue has room. The beat with tlast is followed by a flush
// in the merge stage (a partial beat if entries remain, then the final beat),
// which sends at most one output beat per cycle and takes no new input
// meanwhile. The final beat of a stream passes the lane register, the merge
// stage with its flush and the output queue. Output tdata holds value 0 in
// bits 63:0 up to value 3 in bits 255:192 and the byte keep mask in bits
// 287:256. Bounds sit at byte address 0 (lower) and 8 (upper), 64 bits each;
// the user must change them only while no stream is in flight (not enforced by the block).
module range_filter_stream_compactor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // in_value_0 .. in_value_3, 64 bits each from the lowest bit
  input  logic [rfsc_pkg::IN_W-1:0]     s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  // output stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // out_value_0 .. out_value_3 (64 bits each), then out_keep (32), from the lowest bit
  output logic [rfsc_pkg::OUT_W-1:0]    m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [rfsc_pkg::CFG_W-1:0]    pwdata,
  output logic [rfsc_pkg::CFG_W-1:0]    prdata,
  output logic                          pready
);

  localparam int L = rfsc_pkg::LANES;

  rfsc_pkg::bounds_t bounds_q;
  rfsc_pkg::reg_e    reg_sel;
  logic              cfg_wr;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_last_q;
  logic              s1_load;
  logic              take;

  logic [L-1:0][rfsc_pkg::VAL_W-1:0] lane_in;
  logic [L-1:0][rfsc_pkg::VAL_W-1:0] lane_val;
  logic [L-1:0]                      lane_hit;

  rfsc_pkg::push_t   push;
  logic              push_ready;
  rfsc_pkg::beat_t   out_beat;

  // register decode
  assign pready  = 1'b1;
  assign reg_sel = rfsc_pkg::reg_e'(paddr[3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      rfsc_pkg::REG_LOWER: prdata = bounds_q.lower;
      rfsc_pkg::REG_UPPER: prdata = bounds_q.upper;
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q.lower <= '0;
      bounds_q.upper <= '1;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        rfsc_pkg::REG_LOWER: bounds_q.lower <= pwdata;
        rfsc_pkg::REG_UPPER: bounds_q.upper <= pwdata;
        default:             bounds_q <= bounds_q;
      endcase
    end
  end

  // lane stage handshake
  assign s_axis_tready_o = !s1_valid_q || take;
  assign s1_load         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (take) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_last_q <= s_axis_tlast_i;
    end
  end

  // filter lanes
  for (genvar i = 0; i < L; i++) begin : g_lane
    if (i < rfsc_pkg::SHOWN_LANES) begin : g_fed
      assign lane_in[i] = s_axis_tdata_i[i*rfsc_pkg::VAL_W +: rfsc_pkg::VAL_W];
    end else begin : g_zero
      assign lane_in[i] = '0;
    end

    rfsc_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (s1_load),
      .value_i  (lane_in[i]),
      .bounds_i (bounds_q),
      .value_o  (lane_val[i]),
      .hit_o    (lane_hit[i])
    );
  end

  // packing and hold-back
  rfsc_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s1_valid_q),
    .last_i       (s1_last_q),
    .hits_i       (lane_hit),
    .vals_i       (lane_val),
    .take_o       (take),
    .push_ready_i (push_ready),
    .push_o       (push)
  );

  // output queue
  rfsc_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (push_ready),
    .valid_o (m_axis_tvalid_o),
    .pop_i   (m_axis_tready_i),
    .beat_o  (out_beat)
  );

  assign m_axis_tdata_o = {out_beat.keep, out_beat.vals};
  assign m_axis_tlast_o = out_beat.last;

endmodule

>>> design/rfsc_lane.sv
// one filter lane: range compare and stage register for one value
module rfsc_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  rfsc_pkg::val_t        value_i,
  input  rfsc_pkg::bounds_t     bounds_i,
  output rfsc_pkg::val_t        value_o,
  output logic                  hit_o
);

  rfsc_pkg::val_t value_q;
  logic           hit_q;
  logic           hit_d;

  // inclusive range check, empty when lower exceeds upper
  assign hit_d = (value_i >= bounds_i.lower) && (value_i <= bounds_i.upper);

  // value and hit flag held for the merge stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (en_i) begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_i;
    end
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

>>> design/rfsc_merge.sv
// merge stage: packs lane hits densely, holds back one beat, flushes at stream end
module rfsc_merge (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  logic                                      last_i,
  input  logic [rfsc_pkg::LANES-1:0]                hits_i,
  input  logic [rfsc_pkg::LANES-1:0][rfsc_pkg::VAL_W-1:0] vals_i,
  output logic                                      take_o,
  input  logic                                      push_ready_i,
  output rfsc_pkg::push_t                           push_o
);

  localparam int L = rfsc_pkg::LANES;

  rfsc_pkg::val_t [L-1:0]   pack_q, pack_d;
  logic [rfsc_pkg::CNT_W-1:0] count_q, count_d;
  rfsc_pkg::val_t [L-1:0]   held_vals_q, held_vals_d;
  logic [rfsc_pkg::KEEP_W-1:0] held_keep_q, held_keep_d;
  logic                     held_valid_q, held_valid_d;
  logic                     flush_q, flush_d;

  logic [L-1:0][rfsc_pkg::SUM_W-1:0] pos;
  logic [rfsc_pkg::SUM_W-1:0]        ncount;
  logic                              full;
  rfsc_pkg::val_t [2*L-1:0]          comb;
  rfsc_pkg::beat_t                   held_beat;
  rfsc_pkg::beat_t                   empty_beat;

  // destination slot of each lane and new entry count
  always_comb begin
    logic [rfsc_pkg::SUM_W-1:0] run;
    run = rfsc_pkg::SUM_W'(count_q);
    for (int i = 0; i < L; i++) begin
      pos[i] = run;
      run    = run + rfsc_pkg::SUM_W'(hits_i[i]);
    end
    ncount = run;
    full   = (run >= rfsc_pkg::SUM_W'(L));
  end

  // compaction: stored entries first, then kept lane values in order
  always_comb begin
    for (int j = 0; j < 2 * L; j++) begin
      comb[j] = '0;
      if ((j < L) && (j < int'(count_q))) begin
        comb[j] = pack_q[j % L];
      end
      for (int i = 0; i < L; i++) begin
        if (hits_i[i] && (pos[i] == rfsc_pkg::SUM_W'(j))) begin
          comb[j] = vals_i[i];
        end
      end
    end
  end

  // held beat and the zero beat sent for an empty stream
  always_comb begin
    held_beat      = '0;
    held_beat.keep = held_keep_q;
    for (int j = 0; j < rfsc_pkg::SHOWN_LANES; j++) begin
      held_beat.vals[j] = held_vals_q[j];
    end
    empty_beat      = '0;
    empty_beat.keep = rfsc_pkg::KEEP_W'(1);
  end

  // packing, hold-back and flush sequencing
  always_comb begin
    pack_d       = pack_q;
    count_d      = count_q;
    held_vals_d  = held_vals_q;
    held_keep_d  = held_keep_q;
    held_valid_d = held_valid_q;
    flush_d      = flush_q;
    take_o       = 1'b0;
    push_o       = '0;

    if (!flush_q) begin
      if (valid_i && push_ready_i) begin
        take_o = 1'b1;
        if (full) begin
          // a full beat forms: the previous one goes out
          push_o.valid = held_valid_q;
          push_o.beat  = held_beat;
          for (int j = 0; j < L; j++) begin
            held_vals_d[j] = comb[j];
            pack_d[j]      = comb[j + L];
          end
          held_keep_d  = rfsc_pkg::keep_mask(rfsc_pkg::CNT_W'(L));
          held_valid_d = 1'b1;
          count_d      = rfsc_pkg::CNT_W'(ncount - rfsc_pkg::SUM_W'(L));
        end else begin
          for (int j = 0; j < L; j++) begin
            pack_d[j] = comb[j];
          end
          count_d = rfsc_pkg::CNT_W'(ncount);
        end
        flush_d = last_i;
      end
    end else if (push_ready_i) begin
      if (count_q != '0) begin
        // leftover entries become a partial beat
        push_o.valid = held_valid_q;
        push_o.beat  = held_beat;
        for (int j = 0; j < L; j++) begin
          held_vals_d[j] = (j < int'(count_q)) ? pack_q[j] : '0;
        end
        held_keep_d  = rfsc_pkg::keep_mask(count_q);
        held_valid_d = 1'b1;
        count_d      = '0;
      end else begin
        // final beat of the stream, then back to the idle state
        push_o.valid     = 1'b1;
        push_o.beat      = held_valid_q ? held_beat : empty_beat;
        push_o.beat.last = 1'b1;
        held_valid_d     = 1'b0;
        flush_d          = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      held_valid_q <= 1'b0;
      flush_q      <= 1'b0;
    end else begin
      count_q      <= count_d;
      held_valid_q <= held_valid_d;
      flush_q      <= flush_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    pack_q      <= pack_d;
    held_vals_q <= held_vals_d;
    held_keep_q <= held_keep_d;
  end

endmodule

>>> design/rfsc_out_fifo.sv
// two-entry output queue that decouples the merge stage from the output stream
module rfsc_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rfsc_pkg::push_t   push_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_i,
  output rfsc_pkg::beat_t   beat_o
);

  rfsc_pkg::beat_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign do_push = push_i.valid && ready_o;
  assign do_pop  = valid_o && pop_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.beat;
    end
  end

  assign beat_o = mem_q[rd_ptr_q];

endmodule

>>> dv/tb_range_filter_stream_compactor.sv
// testbench of the range filter stream compactor: random and directed streams, scoreboard check
`timescale 1ns / 1ps

module tb_range_filter_stream_compactor;
  import rfsc_pkg::*;

  localparam val_t VMAX        = '1;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   SETTLE_CYC  = 10;

  // one beat waiting to be sent, with its pacing flags
  typedef struct packed {
    logic                              no_gap;
    logic                              hold_off;
    logic                              last;
    logic [FIELD_LANES-1:0][VAL_W-1:0] vals;
  } src_beat_t;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              s_valid = 1'b0;
  logic              s_ready;
  logic [IN_W-1:0]   s_data  = '0;
  logic              s_last  = 1'b0;
  logic              m_valid;
  logic              m_ready = 1'b0;
  logic [OUT_W-1:0]  m_data;
  logic              m_last;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [CFG_W-1:0]  pwdata  = '0;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  src_beat_t in_beats_q[$];
  beat_t     out_beats_due[$];
  src_beat_t cur_beat;
  logic      burst   = 1'b0;
  logic      gapless = 1'b0;
  int        err_cnt = 0;
  int        cycles  = 0;

  // predictor state
  val_t        lo_bound = '0;
  val_t        hi_bound = '1;
  val_t        pack_vals [2*LANES];
  int unsigned pack_n;
  val_t        held_vals [LANES];
  logic [63:0] held_keep;
  logic        held_valid;
  logic        held_last;

  range_filter_stream_compactor u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // byte mask covering eight bytes per value
  function automatic logic [63:0] keep_for(input int unsigned n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic void clear_pack();
    for (int j = 0; j < 2 * LANES; j++) pack_vals[j] = '0;
    for (int j = 0; j < LANES; j++) held_vals[j] = '0;
    pack_n     = 0;
    held_keep  = 64'd1;
    held_valid = 1'b0;
    held_last  = 1'b0;
  endfunction

  // the held beat becomes an expected output beat
  function automatic void send_held();
    beat_t b;
    b.vals = '0;
    for (int j = 0; j < SHOWN_LANES; j++) b.vals[j] = held_vals[j];
    b.keep = held_keep[KEEP_W-1:0];
    b.last = held_last;
    out_beats_due.push_back(b);
  endfunction

  // move one compacted beat into the hold stage
  function automatic void stage_beat(input logic [63:0] keep, input logic last);
    if (keep != '0) begin
      if (held_valid) send_held();
      for (int j = 0; j < LANES; j++) held_vals[j] = (j < pack_n) ? pack_vals[j] : '0;
      held_keep  = keep;
      held_last  = last;
      held_valid = 1'b1;
    end else if (last) begin
      held_last  = 1'b1;
      held_valid = 1'b1;
    end
  endfunction

  // filter one input beat and queue the output beats it releases
  function automatic void filter_and_pack(input logic [FIELD_LANES-1:0][VAL_W-1:0] vals,
                                          input logic last);
    int unsigned total;
    logic        full_end;
    val_t        v;
    full_end = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      v = (i < FIELD_LANES) ? vals[i] : '0;
      if (lo_bound <= v && v <= hi_bound) begin
        pack_vals[pack_n] = v;
        pack_n++;
      end
    end
    if (pack_n >= LANES) begin
      total    = pack_n;
      full_end = last && (pack_n == LANES);
      pack_n   = LANES;
      stage_beat(keep_for(LANES), full_end);
      pack_n = total - LANES;
      for (int j = 0; j < LANES; j++) begin
        pack_vals[j]         = pack_vals[j + LANES];
        pack_vals[j + LANES] = '0;
      end
    end
    if (last) begin
      if (!full_end) stage_beat(keep_for(pack_n), 1'b1);
      if (held_valid) send_held();
      clear_pack();
    end
  endfunction

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) filter_and_pack(cur_beat.vals, cur_beat.last);
      if (!s_valid || s_ready) begin
        if (in_beats_q.size() != 0 &&
            !(in_beats_q[0].hold_off && out_beats_due.size() != 0) &&
            (in_beats_q[0].no_gap || $urandom_range(99) >= 23)) begin
          cur_beat = in_beats_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= cur_beat.vals;
          s_last  <= cur_beat.last;
          burst   <= cur_beat.no_gap;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and checker
  always @(posedge clk_i) begin : mon
    beat_t got;
    beat_t want;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        got = {m_last, m_data};
        if (out_beats_due.size() == 0) begin
          err_cnt++;
          $display("%0t: output beat with none expected: expected none got %h", $time, got);
        end else begin
          want = out_beats_due.pop_front();
          for (int j = 0; j < FIELD_LANES; j++) begin
            if (got.vals[j] !== want.vals[j]) begin
              err_cnt++;
              $display("%0t: value %0d expected %h got %h", $time, j, want.vals[j],
                       got.vals[j]);
            end
          end
          if (got.keep !== want.keep) begin
            err_cnt++;
            $display("%0t: keep expected %h got %h", $time, want.keep, got.keep);
          end
          if (got.last !== want.last) begin
            err_cnt++;
            $display("%0t: last expected %b got %b", $time, want.last, got.last);
          end
        end
      end
      m_ready <= burst || ($urandom_range(99) >= 23);
    end
  end

  function automatic val_t rand64();
    return {$urandom, $urandom};
  endfunction

  // value near or inside the current bounds, or anywhere
  function automatic val_t pick_value();
    val_t span;
    case ($urandom_range(5))
      0: return lo_bound;
      1: return hi_bound;
      2: return lo_bound - 1;
      3: return hi_bound + 1;
      4: begin
        if (lo_bound > hi_bound) return rand64();
        span = hi_bound - lo_bound;
        if (span == VMAX) return rand64();
        return lo_bound + rand64() % (span + 1);
      end
      default: return rand64();
    endcase
  endfunction

  task automatic push_beat(input val_t a, input val_t b, input val_t c, input val_t d,
                           input logic last, input logic hold = 1'b0);
    src_beat_t s;
    s.vals     = {d, c, b, a};
    s.last     = last;
    s.hold_off = hold;
    s.no_gap   = gapless;
    in_beats_q.push_back(s);
  endtask

  task automatic add_stream(input int n_beats);
    for (int k = 0; k < n_beats; k++) begin
      push_beat(pick_value(), pick_value(), pick_value(), pick_value(), k == n_beats - 1,
                k != 0 && $urandom_range(29) == 0);
    end
  endtask

  // nothing queued, in flight or expected, plus settling time
  task automatic wait_idle();
    do @(negedge clk_i);
    while (in_beats_q.size() != 0 || s_valid || out_beats_due.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_bound(input reg_e r, input val_t v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(8 * int'(r));
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_LOWER) lo_bound = v;
    else hi_bound = v;
  endtask

  task automatic set_bounds(input val_t lo, input val_t hi);
    wait_idle();
    write_bound(REG_LOWER, lo);
    write_bound(REG_UPPER, hi);
  endtask

  // stimulus sequence
  initial begin
    val_t lo;
    clear_pack();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset bounds keep everything: full beat ends the stream, then two full beats
    push_beat('0, VMAX, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    push_beat(64'd1, 64'd2, 64'd3, 64'd4, 1'b0);
    push_beat(VMAX - 1, 64'd6, 64'd7, 64'd8, 1'b1);

    // narrow range: partial ends, spill past one beat, all three outputs at once
    set_bounds(64'd10, 64'd20);
    push_beat(64'd5, 64'd10, 64'd20, 64'd21, 1'b0);
    push_beat(64'd15, 64'd15, 64'd15, 64'd0, 1'b1);
    // waits for the previous stream's output beats to drain
    push_beat(64'd11, 64'd12, 64'd13, 64'd14, 1'b0, 1'b1);
    push_beat(64'd10, 64'd11, 64'd12, 64'd9, 1'b0, 1'b1);
    push_beat(64'd20, 64'd20, 64'd20, 64'd20, 1'b1, 1'b1);
    push_beat(64'd1, 64'd2, 64'd3, 64'd15, 1'b1);
    push_beat(64'd10, 64'd11, 64'd0, 64'd0, 1'b0);
    push_beat(64'd0, 64'd0, 64'd0, 64'd0, 1'b1);
    push_beat(64'd16, 64'd17, 64'd18, 64'd99, 1'b1);
    push_beat(64'd0, 64'd21, VMAX, 64'd9, 1'b1);
    push_beat(64'd10, 64'd11, 64'd12, 64'd13, 1'b0);
    push_beat(64'd0, 64'd0, 64'd0, 64'd0, 1'b1);

    // empty range keeps nothing
    set_bounds(VMAX, '0);
    push_beat(VMAX, '0, 64'd1, VMAX - 1, 1'b0);
    push_beat(64'd7, '0, VMAX, 64'd3, 1'b1);

    // single-point ranges at both ends
    set_bounds('0, '0);
    push_beat('0, 64'd1, '0, VMAX, 1'b1);
    set_bounds(VMAX, VMAX);
    push_beat(VMAX, VMAX - 1, VMAX, '0, 1'b1);

    // random bounds with gaps on both sides
    lo = rand64() >> 2;
    set_bounds(lo, lo + (rand64() >> 1));
    repeat (10) add_stream($urandom_range(1, 6));

    // full range without any gaps
    set_bounds('0, VMAX);
    gapless = 1'b1;
    repeat (8) add_stream($urandom_range(1, 6));
    gapless = 1'b0;

    // fresh random bounds, longer streams
    lo = rand64() >> 2;
    set_bounds(lo, lo + (rand64() >> 1));
    repeat (5) add_stream($urandom_range(1, 8));

    wait_idle();
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
